### sv/svm_pkg.sv
// svm_pkg: shared types and constants of the sixteen-bit stack word machine
// used by svm_if.sv, svm_div.sv and sixteen_bit_stack_vm_core.sv
package svm_pkg;

  localparam int WordW = 16;

  // run status codes
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // item operations
  localparam logic OPN_LOAD = 1'b0;
  localparam logic OPN_EXEC = 1'b1;

  // instruction opcodes
  localparam logic [WordW-1:0] OP_HALT = 16'd0;
  localparam logic [WordW-1:0] OP_SET  = 16'd1;
  localparam logic [WordW-1:0] OP_PUSH = 16'd2;
  localparam logic [WordW-1:0] OP_POP  = 16'd3;
  localparam logic [WordW-1:0] OP_EQ   = 16'd4;
  localparam logic [WordW-1:0] OP_GT   = 16'd5;
  localparam logic [WordW-1:0] OP_JMP  = 16'd6;
  localparam logic [WordW-1:0] OP_JT   = 16'd7;
  localparam logic [WordW-1:0] OP_JF   = 16'd8;
  localparam logic [WordW-1:0] OP_ADD  = 16'd9;
  localparam logic [WordW-1:0] OP_MULT = 16'd10;
  localparam logic [WordW-1:0] OP_MOD  = 16'd11;
  localparam logic [WordW-1:0] OP_AND  = 16'd12;
  localparam logic [WordW-1:0] OP_OR   = 16'd13;
  localparam logic [WordW-1:0] OP_NOT  = 16'd14;
  localparam logic [WordW-1:0] OP_RMEM = 16'd15;
  localparam logic [WordW-1:0] OP_WMEM = 16'd16;
  localparam logic [WordW-1:0] OP_CALL = 16'd17;
  localparam logic [WordW-1:0] OP_RET  = 16'd18;
  localparam logic [WordW-1:0] OP_OUT  = 16'd19;
  localparam logic [WordW-1:0] OP_IN   = 16'd20;
  localparam logic [WordW-1:0] OP_NOOP = 16'd21;

  localparam logic [WordW-1:0] EOF_WORD = 16'hFFFF;

  typedef struct packed {
    logic             start;
    logic [WordW-1:0] dividend;
    logic [WordW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] rem;
  } div_rsp_t;

endpackage

### sv/svm_if.sv
// svm_in_if / svm_out_if: valid/ready channels of the stack word machine
// depends on svm_pkg
interface svm_in_if;
  import svm_pkg::*;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [WordW-1:0] address;
  logic [WordW-1:0] word;
  logic [7:0]       in_char;
  logic             in_eof;

  modport source (output valid, operation, address, word, in_char, in_eof, input ready);
  modport sink   (input valid, operation, address, word, in_char, in_eof, output ready);
endinterface

interface svm_out_if;
  import svm_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic             out_valid;
  logic [7:0]       out_char;
  logic             input_taken;
  logic [WordW-1:0] next_pc;

  modport source (output valid, status, out_valid, out_char, input_taken, next_pc,
                  input ready);
  modport sink   (input valid, status, out_valid, out_char, input_taken, next_pc,
                  output ready);
endinterface

### sv/svm_ram.sv
// svm_ram: generic single-write, single-read ram with registered read data
// no dependencies
module svm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sv/svm_div.sv
// svm_div: restoring remainder unit, one quotient bit per cycle
// depends on svm_pkg for the request and response structs
module svm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  svm_pkg::div_req_t  req,
  output svm_pkg::div_rsp_t  rsp
);
  import svm_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [3:0]       cnt_r;
  logic [WordW-1:0] q_r;
  logic [WordW-1:0] rem_r;
  logic [WordW-1:0] dsr_r;
  logic [WordW:0]   shifted;
  logic [WordW:0]   diff;
  logic             ge;

  assign shifted = {rem_r, q_r[WordW-1]};
  assign ge      = shifted >= {1'b0, dsr_r};
  assign diff    = shifted - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= req.dividend;
        rem_r  <= '0;
        dsr_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= ge ? diff[WordW-1:0] : shifted[WordW-1:0];
        q_r   <= {q_r[WordW-2:0], 1'b0};
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;
endmodule

### sv/sixteen_bit_stack_vm_core.sv
// sixteen_bit_stack_vm_core: sequenced sixteen-bit register/stack word machine
// depends on svm_pkg, svm_if.sv, svm_ram.sv, svm_div.sv
//
// channel  dir  transfer when         payload
// in_ch    in   valid & ready         operation, address, word, in_char, in_eof
// out_ch   out  valid & ready         status, out_valid, out_char, input_taken, next_pc
//
// after reset a clearing pass writes zero to every word of memory, with
// in_ch.ready low throughout
// a load reduces its address and writes the word; an execute makes four fetches
// through the single memory read port, three register-file reads for operands,
// then decode; mod then waits on the divider
// when MEM_WORDS is not a power of two every memory address is reduced by a
// reciprocal multiply, through an added S_AWAIT state on each access
// one item at a time; in_ch.ready is high only while idle, and a new item is
// taken while the previous result still waits in the output register; a
// finished item holds in its last state until that register is free
module sixteen_bit_stack_vm_core #(
  parameter int MEM_WORDS   = 65536,
  parameter int STACK_DEPTH = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  svm_in_if.sink    in_ch,
  svm_out_if.source out_ch
);
  import svm_pkg::*;

  localparam int  AW      = $clog2(MEM_WORDS);
  localparam int  SAW     = $clog2(STACK_DEPTH);
  localparam int  SCW     = $clog2(STACK_DEPTH + 1);
  localparam bit  MemPow2 = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
  // ceil(2^32 / MEM_WORDS), exact quotient for any 16-bit address
  localparam longint unsigned Recip =
    ((64'd1 << 32) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_AREQ, S_AWAIT, S_AUSE, S_FWAIT, S_OPND,
    S_DEC, S_MUL, S_MOD, S_RWAIT, S_POPW, S_RETW, S_DONE
  } state_t;

  // what the reduced memory address is for
  typedef enum logic [1:0] {P_LOAD, P_FETCH, P_RMEM, P_WMEM} purp_t;

  state_t           state_r;
  purp_t            purp_r;
  logic [AW-1:0]    clr_r;
  logic [WordW-1:0] raw_r;
  logic [40:0]      red_r;
  logic [AW-1:0]    midx_r;
  logic [WordW-1:0] wdat_r;
  logic [WordW-1:0] pc_r;
  logic [1:0]       run_r;
  logic [SCW-1:0]   sp_r;
  logic [WordW-1:0] regs_r [8];
  logic [WordW-1:0] fw_r [4];
  logic [WordW-1:0] opv_r [3];
  logic [1:0]       k_r;
  logic [31:0]      prod_r;
  logic [7:0]       chr_r;
  logic             eof_r;
  logic             ov_r;
  logic [7:0]       oc_r;
  logic             tk_r;

  // output register
  logic             ob_v_r;
  logic [1:0]       ob_status_r;
  logic             ob_ov_r;
  logic [7:0]       ob_oc_r;
  logic             ob_tk_r;
  logic [WordW-1:0] ob_pc_r;

  // memory and stack ports
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [WordW-1:0] mem_wdata;
  logic [WordW-1:0] mem_rdata;
  logic             stk_we;
  logic [SAW-1:0]   stk_waddr;
  logic [WordW-1:0] stk_wdata;
  logic [SAW-1:0]   stk_raddr;
  logic [WordW-1:0] stk_rdata;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // decode helpers
  logic [WordW-1:0] op;
  logic [2:0]       dst;
  logic [WordW-1:0] va, vb, vc;
  logic [SCW-1:0]   sp_m1;
  logic             stk_full;
  logic             stk_empty;
  logic [WordW-1:0] opnd_word;
  logic [WordW-1:0] opnd_val;
  logic [WordW:0]   sum;
  logic [1:0]       k_p1;

  // address reduction helpers
  logic [8:0]       quo;
  logic [25:0]      quo_m;
  logic [WordW-1:0] red_idx;

  assign op        = fw_r[0];
  assign dst       = fw_r[1][2:0];
  assign va        = opv_r[0];
  assign vb        = opv_r[1];
  assign vc        = opv_r[2];
  assign sp_m1     = sp_r - SCW'(1);
  assign stk_full  = sp_r == SCW'(STACK_DEPTH);
  assign stk_empty = sp_r == '0;
  assign sum       = {1'b0, vb} + {1'b0, vc};
  assign k_p1      = k_r + 2'd1;

  // address minus quotient times depth
  assign quo     = red_r[40:32];
  assign quo_m   = 26'(quo) * 26'(MEM_WORDS);
  assign red_idx = raw_r - quo_m[WordW-1:0];

  // operand resolution: one register-file read per cycle
  assign opnd_word = fw_r[k_p1];
  assign opnd_val  = opnd_word[WordW-1] ? regs_r[opnd_word[2:0]] : opnd_word;

  svm_ram #(.WIDTH(WordW), .DEPTH(MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (midx_r),
    .rdata (mem_rdata)
  );

  svm_ram #(.WIDTH(WordW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  svm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // memory write port: clearing sweep, load items and wmem
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = midx_r;
    mem_wdata = wdat_r;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else if (state_r == S_AUSE && (purp_r == P_LOAD || purp_r == P_WMEM)) begin
      mem_we = 1'b1;
    end
  end

  // stack port: push and call write at the top, pop and ret read below it
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = sp_r[SAW-1:0];
    stk_wdata = (op == OP_CALL) ? pc_r + 16'd2 : va;
    stk_raddr = sp_m1[SAW-1:0];
    if (state_r == S_DEC && (op == OP_PUSH || op == OP_CALL) && !stk_full) begin
      stk_we = 1'b1;
    end
  end

  // divider: used by mod only
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = vb;
    div_req.divisor  = vc;
    if (state_r == S_DEC && op == OP_MOD && vc != '0) begin
      div_req.start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      pc_r    <= '0;
      run_r   <= ST_RUN;
      sp_r    <= '0;
      ob_v_r  <= 1'b0;
      k_r     <= '0;
      for (int i = 0; i < 8; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      if (ob_v_r && out_ch.ready && state_r != S_DONE) begin
        ob_v_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(MEM_WORDS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            chr_r  <= in_ch.in_char;
            eof_r  <= in_ch.in_eof;
            ov_r   <= 1'b0;
            oc_r   <= '0;
            tk_r   <= 1'b0;
            k_r    <= '0;
            wdat_r <= in_ch.word;
            if (in_ch.operation == OPN_LOAD) begin
              raw_r   <= in_ch.address;
              purp_r  <= P_LOAD;
              state_r <= S_AREQ;
            end else if (run_r != ST_RUN) begin
              state_r <= S_DONE;
            end else begin
              raw_r   <= pc_r;
              purp_r  <= P_FETCH;
              state_r <= S_AREQ;
            end
          end
        end
        S_AREQ: begin
          if (MemPow2) begin
            midx_r  <= raw_r[AW-1:0];
            state_r <= S_AUSE;
          end else begin
            red_r   <= 41'(raw_r) * 41'(Recip);
            state_r <= S_AWAIT;
          end
        end
        S_AWAIT: begin
          midx_r  <= red_idx[AW-1:0];
          state_r <= S_AUSE;
        end
        S_AUSE: begin
          unique case (purp_r)
            P_LOAD, P_WMEM: state_r <= S_DONE;
            P_FETCH:        state_r <= S_FWAIT;
            P_RMEM:         state_r <= S_RWAIT;
            default:        state_r <= S_DONE;
          endcase
        end
        S_FWAIT: begin
          fw_r[k_r] <= mem_rdata;
          if (k_r == 2'd3) begin
            k_r     <= '0;
            state_r <= S_OPND;
          end else begin
            k_r     <= k_p1;
            raw_r   <= pc_r + {14'd0, k_p1};
            state_r <= S_AREQ;
          end
        end
        S_OPND: begin
          opv_r[k_r] <= opnd_val;
          if (k_r == 2'd2) begin
            state_r <= S_DEC;
          end else begin
            k_r <= k_p1;
          end
        end
        S_DEC: begin
          prod_r  <= vb * vc;
          state_r <= S_DONE;
          unique case (op)
            OP_HALT: run_r <= ST_HALT;
            OP_SET: begin
              regs_r[dst] <= vb;
              pc_r        <= pc_r + 16'd3;
            end
            OP_PUSH: begin
              if (stk_full) begin
                run_r <= ST_ERR;
              end else begin
                sp_r <= sp_r + SCW'(1);
                pc_r <= pc_r + 16'd2;
              end
            end
            OP_POP: begin
              if (stk_empty) begin
                run_r <= ST_ERR;
              end else begin
                sp_r    <= sp_m1;
                state_r <= S_POPW;
              end
            end
            OP_EQ: begin
              regs_r[dst] <= {15'd0, vb == vc};
              pc_r        <= pc_r + 16'd4;
            end
            OP_GT: begin
              regs_r[dst] <= {15'd0, vb > vc};
              pc_r        <= pc_r + 16'd4;
            end
            OP_JMP: pc_r <= va;
            OP_JT:  pc_r <= (va != '0) ? vb : pc_r + 16'd3;
            OP_JF:  pc_r <= (va == '0) ? vb : pc_r + 16'd3;
            OP_ADD: begin
              regs_r[dst] <= {1'b0, sum[14:0]};
              pc_r        <= pc_r + 16'd4;
            end
            OP_MULT: state_r <= S_MUL;
            OP_MOD: begin
              if (vc == '0) begin
                run_r <= ST_ERR;
              end else begin
                state_r <= S_MOD;
              end
            end
            OP_AND: begin
              regs_r[dst] <= vb & vc;
              pc_r        <= pc_r + 16'd4;
            end
            OP_OR: begin
              regs_r[dst] <= vb | vc;
              pc_r        <= pc_r + 16'd4;
            end
            OP_NOT: begin
              regs_r[dst] <= {1'b0, ~vb[14:0]};
              pc_r        <= pc_r + 16'd3;
            end
            OP_RMEM: begin
              raw_r   <= vb;
              purp_r  <= P_RMEM;
              state_r <= S_AREQ;
            end
            OP_WMEM: begin
              raw_r   <= va;
              wdat_r  <= vb;
              purp_r  <= P_WMEM;
              pc_r    <= pc_r + 16'd3;
              state_r <= S_AREQ;
            end
            OP_CALL: begin
              if (stk_full) begin
                run_r <= ST_ERR;
              end else begin
                sp_r <= sp_r + SCW'(1);
                pc_r <= va;
              end
            end
            OP_RET: begin
              if (stk_empty) begin
                run_r <= ST_HALT;
              end else begin
                sp_r    <= sp_m1;
                state_r <= S_RETW;
              end
            end
            OP_OUT: begin
              ov_r <= 1'b1;
              oc_r <= va[7:0];
              pc_r <= pc_r + 16'd2;
            end
            OP_IN: begin
              regs_r[dst] <= eof_r ? EOF_WORD : {8'd0, chr_r};
              tk_r        <= 1'b1;
              pc_r        <= pc_r + 16'd2;
            end
            OP_NOOP: pc_r <= pc_r + 16'd1;
            default: run_r <= ST_ERR;
          endcase
        end
        S_MUL: begin
          regs_r[dst] <= {1'b0, prod_r[14:0]};
          pc_r        <= pc_r + 16'd4;
          state_r     <= S_DONE;
        end
        S_MOD: begin
          if (div_rsp.done) begin
            regs_r[dst] <= div_rsp.rem;
            pc_r        <= pc_r + 16'd4;
            state_r     <= S_DONE;
          end
        end
        S_RWAIT: begin
          regs_r[dst] <= mem_rdata;
          pc_r        <= pc_r + 16'd3;
          state_r     <= S_DONE;
        end
        S_POPW: begin
          regs_r[dst] <= stk_rdata;
          pc_r        <= pc_r + 16'd2;
          state_r     <= S_DONE;
        end
        S_RETW: begin
          pc_r    <= stk_rdata;
          state_r <= S_DONE;
        end
        S_DONE: begin
          // hold here while a previous result is still unclaimed
          if (!ob_v_r || out_ch.ready) begin
            ob_v_r      <= 1'b1;
            ob_status_r <= run_r;
            ob_ov_r     <= ov_r;
            ob_oc_r     <= oc_r;
            ob_tk_r     <= tk_r;
            ob_pc_r     <= pc_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready        = state_r == S_IDLE;
  assign out_ch.valid       = ob_v_r;
  assign out_ch.status      = ob_status_r;
  assign out_ch.out_valid   = ob_ov_r;
  assign out_ch.out_char    = ob_oc_r;
  assign out_ch.input_taken = ob_tk_r;
  assign out_ch.next_pc     = ob_pc_r;

  // stack never grows past its depth
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SCW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // a halted machine never runs again until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    run_r != ST_RUN |=> run_r != ST_RUN)
    else $error("machine left halted state");

  // one instruction cannot both emit and consume a character
  a_one_io: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.out_valid && out_ch.input_taken))
    else $error("out and in flags both set");

  // a result is shown only with a pc that matches the machine state
  a_result_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!ob_v_r || out_ch.ready)) |=> ob_pc_r == pc_r)
    else $error("result pc differs from program counter");
endmodule
